// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: request opcodes,
// sequencer states, control characters and the sweep unit control bundle.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // request opcodes
   typedef enum logic [1:0] {
      OP_PUT_CHAR   = 2'd0,
      OP_SET_CURSOR = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_READ_CELL  = 2'd3
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_SWEEP
   } state_type;

   // control characters
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;

   localparam int TAB_STEP = 4;
   localparam int CELL_W   = 16;

   // sequencer to sweep unit
   typedef struct packed {
      logic start;
      logic scroll;   // 1: move rows up and blank the bottom row, 0: blank all
   } sweep_cmd_type;

   // sweep unit to sequencer
   typedef struct packed {
      logic active;
      logic done;     // last write of the sweep is on the write port
   } sweep_stat_type;

endpackage

// File: design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: a character-cell store with a cursor, driven by
// put-char, set-cursor, clear and read-cell requests.
// ----------------------------------------------------------------------------
//   channel   ports                         handshake
//   request   start, busy, req_*            taken at a clock edge with start=1, busy=0
//   response  rsp_valid, rsp_*              one-cycle strobe, always taken
//
// A put-char or set-cursor request gives its registered response strobe after
// the EXEC state; a read-cell request also passes through READ_WAIT first.
// A scroll or clear walks the store one cell per cycle, a rate set by the
// single write port of the cell store. After reset the store is blanked by the
// same walk, with busy high. busy stays high from acceptance until the response.
// ----------------------------------------------------------------------------
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_attribute,
   input  logic [7:0]  req_target_col,
   input  logic [7:0]  req_target_row,
   input  logic [10:0] req_cell_address,
   output logic        rsp_valid,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [15:0] rsp_cell_value,
   output logic        rsp_scrolled
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(COLS);
   localparam int RW = $clog2(ROWS);
   localparam logic [CW:0]   COLS_X   = (CW+1)'(COLS);
   localparam logic [RW:0]   ROWS_X   = (RW+1)'(ROWS);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

   state_type state_ff, state_in;

   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic          scrolled_ff, scrolled_in;

   // request held while it is worked on
   op_type        op_ff;
   logic [7:0]    code_ff, attr_ff, tcol_ff, trow_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          accept;

   // response registers
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_col_ff;
   logic [RW-1:0] rsp_row_ff;
   logic [15:0]   rsp_value_ff;
   logic          rsp_scrolled_ff;
   logic          resp_fire;
   logic [15:0]   resp_value;
   logic          resp_scrolled;

   // cell store ports
   logic              ex_wr_en, ex_rd_en;
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [CELL_W-1:0] ram_wr_data, ram_rd_data;

   sweep_cmd_type     sw_cmd;
   sweep_stat_type    sw_stat;
   logic              sw_rd_en, sw_wr_en;
   logic [AW-1:0]     sw_rd_addr, sw_wr_addr;
   logic [CELL_W-1:0] sw_wr_data;

   logic [CW:0]     col_nx;
   logic [RW:0]     row_nx;
   logic            row_inc;
   logic [AW+10:0]  req_addr_ext;
   logic [CW+6:0]   col_port;
   logic [RW+4:0]   row_port;

   assign accept       = start && !busy;
   assign busy         = (state_ff != ST_IDLE);
   assign req_addr_ext = {{AW{1'b0}}, req_cell_address};

   always_comb begin
      state_in      = state_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      scrolled_in   = scrolled_ff;
      addr_in       = addr_ff;
      rd_ok_in      = rd_ok_ff;
      ex_wr_en      = 1'b0;
      ex_rd_en      = 1'b0;
      sw_cmd        = '0;
      resp_fire     = 1'b0;
      resp_value    = '0;
      resp_scrolled = 1'b0;
      col_nx        = {1'b0, cur_col_ff};
      row_inc       = 1'b0;
      row_nx        = {1'b0, cur_row_ff};

      unique case (state_ff)
         ST_INIT: begin
            if (sw_stat.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               rd_ok_in = (32'(req_cell_address) < CELLS);
               if (op_type'(req_opcode) == OP_READ_CELL) begin
                  addr_in = req_addr_ext[AW-1:0];
               end else begin
                  addr_in = AW'(cur_row_ff * COLS + cur_col_ff);
               end
            end
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_PUT_CHAR: begin
                  if (code_ff == CH_NEWLINE) begin
                     col_nx  = '0;
                     row_inc = 1'b1;
                  end else if (code_ff == CH_RETURN) begin
                     col_nx = '0;
                  end else if (code_ff == CH_TAB) begin
                     col_nx = {1'b0, cur_col_ff} + (CW+1)'(TAB_STEP);
                  end else begin
                     ex_wr_en = 1'b1;
                     col_nx   = {1'b0, cur_col_ff} + (CW+1)'(1);
                  end
                  // wrap past the last column
                  if (col_nx >= COLS_X) begin
                     col_nx  = '0;
                     row_inc = 1'b1;
                  end
                  row_nx     = {1'b0, cur_row_ff} + {{RW{1'b0}}, row_inc};
                  cur_col_in = col_nx[CW-1:0];
                  if (row_nx >= ROWS_X) begin
                     cur_row_in    = LAST_ROW;
                     scrolled_in   = 1'b1;
                     sw_cmd.start  = 1'b1;
                     sw_cmd.scroll = 1'b1;
                     state_in      = ST_SWEEP;
                  end else begin
                     cur_row_in = row_nx[RW-1:0];
                     resp_fire  = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               OP_SET_CURSOR: begin
                  if ((tcol_ff < 8'(COLS)) && (trow_ff < 8'(ROWS))) begin
                     cur_col_in = tcol_ff[CW-1:0];
                     cur_row_in = trow_ff[RW-1:0];
                  end
                  resp_fire = 1'b1;
                  state_in  = ST_IDLE;
               end
               OP_CLEAR: begin
                  cur_col_in    = '0;
                  cur_row_in    = '0;
                  scrolled_in   = 1'b0;
                  sw_cmd.start  = 1'b1;
                  sw_cmd.scroll = 1'b0;
                  state_in      = ST_SWEEP;
               end
               OP_READ_CELL: begin
                  ex_rd_en = rd_ok_ff;
                  state_in = ST_READ_WAIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_READ_WAIT: begin
            resp_fire  = 1'b1;
            resp_value = rd_ok_ff ? ram_rd_data : '0;
            state_in   = ST_IDLE;
         end
         ST_SWEEP: begin
            if (sw_stat.done) begin
               resp_fire     = 1'b1;
               resp_scrolled = scrolled_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         scrolled_ff  <= scrolled_in;
         rsp_valid_ff <= resp_fire;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      rd_ok_ff <= rd_ok_in;
      if (accept) begin
         op_ff   <= op_type'(req_opcode);
         code_ff <= req_char_code;
         attr_ff <= req_attribute;
         tcol_ff <= req_target_col;
         trow_ff <= req_target_row;
      end
      if (resp_fire) begin
         rsp_col_ff      <= cur_col_in;
         rsp_row_ff      <= cur_row_in;
         rsp_value_ff    <= resp_value;
         rsp_scrolled_ff <= resp_scrolled;
      end
   end

   // sweep and request accesses never overlap
   assign ram_wr_en   = sw_wr_en || ex_wr_en;
   assign ram_wr_addr = sw_wr_en ? sw_wr_addr : addr_ff;
   assign ram_wr_data = sw_wr_en ? sw_wr_data : {attr_ff, code_ff};
   assign ram_rd_en   = sw_rd_en || ex_rd_en;
   assign ram_rd_addr = sw_rd_en ? sw_rd_addr : addr_ff;

   tcw_sweep #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sw_cmd),
      .status  (sw_stat),
      .rd_en   (sw_rd_en),
      .rd_addr (sw_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (sw_wr_en),
      .wr_addr (sw_wr_addr),
      .wr_data (sw_wr_data)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign col_port = {7'd0, rsp_col_ff};
   assign row_port = {5'd0, rsp_row_ff};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = col_port[6:0];
   assign rsp_cursor_row = row_port[4:0];
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule

// File: design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tcw_sweep.sv
// ----------------------------------------------------------------------------
// tcw_sweep
// Shared sweep unit: one address counter walks the cell store one cell per
// cycle, either blanking every cell or copying each cell from one row below
// and blanking the bottom row. Each cell is read in the cycle before it is written.
// ----------------------------------------------------------------------------
module tcw_sweep
   import tcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 25,
   localparam int CELLS = COLS * ROWS,
   localparam int AW = $clog2(CELLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  sweep_cmd_type     cmd,
   output sweep_stat_type    status,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [CELL_W-1:0] rd_data,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [CELL_W-1:0] wr_data
);

   localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_END = AW'(CELLS - COLS);
   localparam logic [AW-1:0] ROW_STEP = AW'(COLS);

   logic          active_ff, active_in;
   logic          scroll_ff, scroll_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic          wr_zero_ff, wr_zero_in;
   logic          last_ff, last_in;
   logic          copy_cell;

   assign copy_cell = scroll_ff && (idx_ff < COPY_END);

   always_comb begin
      active_in  = active_ff;
      scroll_in  = scroll_ff;
      idx_in     = idx_ff;
      wr_pend_in = 1'b0;
      wr_idx_in  = wr_idx_ff;
      wr_zero_in = wr_zero_ff;
      last_in    = last_ff;
      if (active_ff) begin
         wr_pend_in = 1'b1;
         wr_idx_in  = idx_ff;
         wr_zero_in = !copy_cell;
         last_in    = (idx_ff == LAST_IDX);
         idx_in     = idx_ff + AW'(1);
         if (idx_ff == LAST_IDX) begin
            active_in = 1'b0;
         end
      end else if (cmd.start) begin
         active_in = 1'b1;
         scroll_in = cmd.scroll;
         idx_in    = '0;
      end
   end

   // reset starts a blanking pass over the whole store
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b1;
         scroll_ff  <= 1'b0;
         idx_ff     <= '0;
         wr_pend_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         active_ff  <= active_in;
         scroll_ff  <= scroll_in;
         idx_ff     <= idx_in;
         wr_pend_ff <= wr_pend_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff  <= wr_idx_in;
      wr_zero_ff <= wr_zero_in;
   end

   assign rd_en   = active_ff && copy_cell;
   assign rd_addr = idx_ff + ROW_STEP;
   assign wr_en   = wr_pend_ff;
   assign wr_addr = wr_idx_ff;
   assign wr_data = wr_zero_ff ? '0 : rd_data;

   assign status.active = active_ff;
   assign status.done   = wr_pend_ff && last_ff;

endmodule

// File: dv/console_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_tracker
// Watches the request and response channels of the text console writer,
// keeps its own copy of the cell store and cursor, predicts each response
// and compares it field by field. Mismatches and leftovers are counted.
// ----------------------------------------------------------------------------
module console_tracker
   import tcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_attribute,
   input  logic [7:0]  req_target_col,
   input  logic [7:0]  req_target_row,
   input  logic [10:0] req_cell_address,
   input  logic        rsp_valid,
   input  logic [6:0]  rsp_cursor_col,
   input  logic [4:0]  rsp_cursor_row,
   input  logic [15:0] rsp_cell_value,
   input  logic        rsp_scrolled,
   output int          fail_count,
   output int          outstanding
);

   localparam int CELLS = COLS * ROWS;

   typedef struct {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [15:0] cell_value;
      logic        scrolled;
   } console_resp_type;

   logic [15:0]      screen [0:CELLS-1];
   int               col_pos;
   int               row_pos;
   int               mismatches;
   console_resp_type pending_resp_q [$];

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
   endfunction

   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
   endfunction

   // returns 1 when the character pushed the cursor off the bottom row
   function automatic logic type_char(logic [7:0] code, logic [7:0] attr);
      logic rolled;
      rolled = 1'b0;
      if (code == CH_NEWLINE) begin
         row_pos++;
         col_pos = 0;
      end else if (code == CH_RETURN) begin
         col_pos = 0;
      end else if (code == CH_TAB) begin
         col_pos += TAB_STEP;
      end else if (col_pos < COLS && row_pos < ROWS) begin
         screen[row_pos * COLS + col_pos] = {attr, code};
         col_pos++;
      end
      // leftover tab columns are dropped on wrap
      if (col_pos >= COLS) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= ROWS) begin
         scroll_screen();
         row_pos = ROWS - 1;
         rolled = 1'b1;
      end
      return rolled;
   endfunction

   function automatic console_resp_type apply_request();
      console_resp_type r;
      r.cell_value = '0;
      r.scrolled   = 1'b0;
      case (op_type'(req_opcode))
         OP_PUT_CHAR: begin
            r.scrolled = type_char(req_char_code, req_attribute);
         end
         OP_SET_CURSOR: begin
            if (req_target_col < COLS && req_target_row < ROWS) begin
               col_pos = int'(req_target_col);
               row_pos = int'(req_target_row);
            end
         end
         OP_CLEAR: begin
            blank_screen();
            col_pos = 0;
            row_pos = 0;
         end
         OP_READ_CELL: begin
            if (req_cell_address < CELLS) r.cell_value = screen[req_cell_address];
         end
         default: ;
      endcase
      r.cursor_col = col_pos[6:0];
      r.cursor_row = row_pos[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      console_resp_type want;
      if (reset) begin
         blank_screen();
         col_pos = 0;
         row_pos = 0;
         pending_resp_q.delete();
      end else begin
         // response first: a new request may be taken on the same edge
         if (rsp_valid) begin
            if (pending_resp_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = pending_resp_q.pop_front();
               if (rsp_cursor_col !== want.cursor_col) begin
                  $error("cursor_col: expected %0d, actual %0d",
                         want.cursor_col, rsp_cursor_col);
                  mismatches++;
               end
               if (rsp_cursor_row !== want.cursor_row) begin
                  $error("cursor_row: expected %0d, actual %0d",
                         want.cursor_row, rsp_cursor_row);
                  mismatches++;
               end
               if (rsp_cell_value !== want.cell_value) begin
                  $error("cell_value: expected %h, actual %h",
                         want.cell_value, rsp_cell_value);
                  mismatches++;
               end
               if (rsp_scrolled !== want.scrolled) begin
                  $error("scrolled: expected %0b, actual %0b",
                         want.scrolled, rsp_scrolled);
                  mismatches++;
               end
            end
         end
         if (start && !busy) pending_resp_q.push_back(apply_request());
      end
      fail_count  <= mismatches;
      outstanding <= pending_resp_q.size();
   end

endmodule

// File: dv/tb_text_console_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Drives the text console writer with directed and random put-char,
// set-cursor, clear and read-cell requests under varying sender idling;
// the console tracker predicts and checks every response.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = COLS * ROWS;
   // each scroll or clear costs a full store walk, so keep them bounded
   localparam int SWEEP_BUDGET    = 100;
   localparam int PHASE_REQUESTS  = 150;
   localparam int DRAIN_LIMIT     = 10000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [7:0]  req_char_code;
   logic [7:0]  req_attribute;
   logic [7:0]  req_target_col;
   logic [7:0]  req_target_row;
   logic [10:0] req_cell_address;
   logic        rsp_valid;
   logic [6:0]  rsp_cursor_col;
   logic [4:0]  rsp_cursor_row;
   logic [15:0] rsp_cell_value;
   logic        rsp_scrolled;

   int fail_count;
   int outstanding;
   int idle_pct     = 0;
   int sent_cnt     = 0;
   int clear_cnt    = 0;
   int scroll_cnt   = 0;
   int last_col     = 0;
   int last_row     = 0;

   text_console_writer #(.COLS(COLS), .ROWS(ROWS)) dut (.*);

   console_tracker #(.COLS(COLS), .ROWS(ROWS)) u_tracker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("tb: failure");
      $finish;
   end

   // cursor seen in the last response steers reads toward written cells
   always @(posedge clock) begin
      if (rsp_valid) begin
         last_col <= int'(rsp_cursor_col);
         last_row <= int'(rsp_cursor_row);
         if (rsp_scrolled) scroll_cnt <= scroll_cnt + 1;
      end
   end

   task automatic issue(input op_type op, input logic [7:0] code, input logic [7:0] attr,
                        input logic [7:0] col, input logic [7:0] row,
                        input logic [10:0] addr);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_opcode       <= op;
      req_char_code    <= code;
      req_attribute    <= attr;
      req_target_col   <= col;
      req_target_row   <= row;
      req_cell_address <= addr;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      sent_cnt++;
      if (op == OP_CLEAR) clear_cnt++;
   endtask

   // unused fields carry random junk
   task automatic put_char(input logic [7:0] code, input logic [7:0] attr);
      issue(OP_PUT_CHAR, code, attr, 8'($urandom_range(255)), 8'($urandom_range(255)),
            11'($urandom_range(2047)));
   endtask

   task automatic set_cursor(input logic [7:0] col, input logic [7:0] row);
      issue(OP_SET_CURSOR, 8'($urandom_range(255)), 8'($urandom_range(255)), col, row,
            11'($urandom_range(2047)));
   endtask

   task automatic read_cell(input logic [10:0] addr);
      issue(OP_READ_CELL, 8'($urandom_range(255)), 8'($urandom_range(255)),
            8'($urandom_range(255)), 8'($urandom_range(255)), addr);
   endtask

   task automatic clear_screen();
      issue(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
            8'($urandom_range(255)), 8'($urandom_range(255)),
            11'($urandom_range(2047)));
   endtask

   task automatic random_request();
      int         pick;
      int         sel;
      int         base;
      int         back;
      bit         tight;
      logic [7:0] code;
      tight = (scroll_cnt + clear_cnt) >= SWEEP_BUDGET;
      pick  = $urandom_range(99);
      sel   = $urandom_range(99);
      if (pick < 55) begin
         if (!tight && sel < 8)       code = CH_NEWLINE;
         else if (!tight && sel < 14) code = CH_TAB;
         else if (sel < 19)           code = CH_RETURN;
         else                         code = 8'($urandom_range(255));
         if (tight && (code == CH_NEWLINE || code == CH_TAB)) code = CH_RETURN;
         put_char(code, 8'($urandom_range(255)));
      end else if (pick < 70) begin
         if (sel < 20)
            set_cursor(8'($urandom_range(255)), 8'($urandom_range(255)));
         else if (!tight && sel < 45)
            set_cursor(8'($urandom_range(COLS - 1)), 8'(ROWS - 1));
         else
            set_cursor(8'($urandom_range(COLS - 1)),
                       8'($urandom_range(tight ? ROWS - 2 : ROWS - 1)));
      end else if (pick < 72 && !tight) begin
         clear_screen();
      end else begin
         if (sel < 60) begin
            // just behind the cursor, where recent characters landed
            base = last_row * COLS + last_col;
            back = $urandom_range(8) + 1;
            read_cell(11'(base >= back ? base - back : 0));
         end else if (sel < 90) begin
            read_cell(11'($urandom_range(CELLS - 1)));
         end else begin
            read_cell(11'($urandom_range(2047)));
         end
      end
   endtask

   initial begin
      int guard;
      int phase_idle [3];
      phase_idle       = '{38, 53, 0};
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = OP_PUT_CHAR;
      req_char_code    = '0;
      req_attribute    = '0;
      req_target_col   = '0;
      req_target_row   = '0;
      req_cell_address = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, control characters, wrap, scroll, bad input
      read_cell(11'd0);
      put_char(8'h41, 8'hFF);
      put_char(8'hFF, 8'h00);
      put_char(8'h00, 8'hA5);
      read_cell(11'd0);
      read_cell(11'd2);
      put_char(CH_TAB, 8'h11);
      put_char(CH_RETURN, 8'h22);
      put_char(CH_NEWLINE, 8'h33);
      set_cursor(8'(COLS - 1), 8'd0);
      put_char(8'h7A, 8'h3C);
      read_cell(11'(COLS - 1));
      set_cursor(8'(COLS - 3), 8'd3);
      put_char(CH_TAB, 8'h44);
      set_cursor(8'(COLS), 8'd0);
      set_cursor(8'd0, 8'(ROWS));
      set_cursor(8'hFF, 8'hFF);
      set_cursor(8'(COLS - 1), 8'(ROWS - 1));
      put_char(8'h23, 8'h7E);
      read_cell(11'(CELLS - COLS - 1));
      set_cursor(8'd5, 8'(ROWS - 1));
      put_char(CH_NEWLINE, 8'h55);
      set_cursor(8'(COLS - 2), 8'(ROWS - 1));
      put_char(CH_TAB, 8'h66);
      read_cell(11'(CELLS - 1));
      read_cell(11'(CELLS));
      read_cell(11'h7FF);
      clear_screen();
      read_cell(11'(CELLS - 2 * COLS - 1));

      for (int p = 0; p < 3; p++) begin
         idle_pct = phase_idle[p];
         repeat (PHASE_REQUESTS) random_request();
      end
      @(negedge clock);
      start <= 1'b0;

      guard = 0;
      while (outstanding != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);

      $display("run covered %0d requests, %0d scrolls and %0d clears,", sent_cnt,
               scroll_cnt, clear_cnt);
      $display("with sender idling at 38, 53 and 0 percent");
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_sweep.sv
design/text_console_writer.sv
dv/console_tracker.sv
dv/tb_text_console_writer.sv
